// File: sv/random_unvisited_selector_defines.svh
// ----------------------------------------------------------------------------
// Random unvisited selector: assertion macros
// Shared helpers for the concurrent checks of the selector.
// ----------------------------------------------------------------------------
`ifndef RANDOM_UNVISITED_SELECTOR_DEFINES_SVH
`define RANDOM_UNVISITED_SELECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RUS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rus_pkg.sv
// ----------------------------------------------------------------------------
// rus_pkg
// Types and constants shared by the random unvisited selector modules.
// ----------------------------------------------------------------------------
package rus_pkg;

  // Field widths
  localparam int unsigned RANK_W     = 4;
  localparam int unsigned RAND_W     = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned DIV_CNT_W  = 5;

  // Result kind codes
  localparam logic KIND_PICK  = 1'b0;
  localparam logic KIND_ORDER = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP,
    S_PICK_WAIT,
    S_PICK_OUT,
    S_ERR,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  // Remainder unit response
  typedef struct packed {
    logic              done;
    logic [RANK_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: sv/rus_mod.sv
// ----------------------------------------------------------------------------
// rus_mod
// Bit-serial remainder unit: dividend mod divisor, one dividend bit a cycle.
// ----------------------------------------------------------------------------
module rus_mod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rus_pkg::RAND_W-1:0]     dividend_i,
  input  logic [rus_pkg::RANK_W-1:0]     divisor_i,
  output rus_pkg::div_rsp_t              rsp_o
);

  logic                            busy_q;
  logic [rus_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [rus_pkg::RAND_W-1:0]      shreg_q;
  logic [rus_pkg::RANK_W-1:0]      rem_q;
  logic [rus_pkg::RANK_W-1:0]      dvs_q;
  logic [rus_pkg::RANK_W:0]        trial;
  logic [rus_pkg::RANK_W-1:0]      rem_next;

  // Restoring step: shift in next bit, subtract divisor when it fits
  always_comb begin
    trial = {rem_q, shreg_q[rus_pkg::RAND_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_next = rus_pkg::RANK_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_next = trial[rus_pkg::RANK_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= rus_pkg::DIV_CNT_W'(rus_pkg::RAND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == rus_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q <= dividend_i;
      rem_q   <= '0;
      dvs_q   <= divisor_i;
    end else if (busy_q) begin
      shreg_q <= {shreg_q[rus_pkg::RAND_W-2:0], 1'b0};
      rem_q   <= rem_next;
    end
  end

  assign rsp_o.done = !busy_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: sv/random_unvisited_selector.sv
// ----------------------------------------------------------------------------
// random_unvisited_selector
// Builds a random visit order: removes each visited rank from the remaining
// list by swap-with-last and picks the next one as remaining[rand mod count].
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid/in_ready      visited_rank, random_value
//  out      out  out_valid/out_ready    kind, rank_out, status, last
//  cfg      in   cfg_valid/cfg_ready    participant_count
//
// One item at a time. A pick waits on the bit-serial remainder unit,
// which runs beside the remaining-list scan (one entry a cycle, up to 16).
// A final visit reads each order beat in S_DUMP_RD, sends it in S_DUMP_OUT,
// via the single visit-order read port. Reset is asynchronous, active low;
// the remaining list reads as identity through per-entry valid bits, so no
// clearing pass. A stalled output holds the sequencer; a finished beat
// waiting in the output register does not block the next input.
// ----------------------------------------------------------------------------
`include "random_unvisited_selector_defines.svh"

module random_unvisited_selector #(
  parameter int unsigned MAX_PARTICIPANTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input beats
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rus_pkg::RANK_W-1:0]       visited_rank_i,
  input  logic [rus_pkg::RAND_W-1:0]       random_value_i,
  // result beats
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kind_o,
  output logic [rus_pkg::RANK_W-1:0]       rank_out_o,
  output logic [rus_pkg::STATUS_W-1:0]     status_o,
  output logic                             last_o,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rus_pkg::CNT_W-1:0]        participant_count_i
);

  localparam int unsigned CntW         = rus_pkg::CNT_W;
  localparam int unsigned RankW        = rus_pkg::RANK_W;
  localparam int unsigned Depth        = rus_pkg::LIST_DEPTH;
  localparam int unsigned CountHighInt =
    (MAX_PARTICIPANTS < Depth) ? MAX_PARTICIPANTS : Depth;
  localparam logic [CntW-1:0] CountHigh = CntW'(CountHighInt);
  localparam logic [CntW-1:0] CountLow  = CntW'(2);

  rus_pkg::state_e state_q, state_d;

  logic [CntW-1:0]   eff_q, eff_d;
  logic [CntW-1:0]   rc_q, rc_d;
  logic [CntW-1:0]   vc_q, vc_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [RankW-1:0]  slot_q, slot_d;
  logic [RankW-1:0]  vis_rank_q, vis_rank_d;
  logic [Depth-1:0]  rem_vld_q;
  logic [RankW-1:0]  rem_mem [Depth];
  logic [RankW-1:0]  vo_mem [Depth];
  logic [RankW-1:0]  rd_data_q;
  logic [RankW-1:0]  vo_rd_q;

  logic                          out_valid_q;
  logic                          out_kind_q, out_kind_d;
  logic [RankW-1:0]              out_rank_q, out_rank_d;
  logic [rus_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic                          out_last_q, out_last_d;
  logic                          out_load;
  logic                          out_free;

  logic              in_acc;
  logic              cfg_acc;
  logic [CntW-1:0]   cfg_eff;
  logic              hit;
  logic              dump_last;
  logic              rd_en;
  logic [RankW-1:0]  rd_addr;
  logic              rem_wr;
  logic              vo_wr;
  logic              vo_rd_en;
  logic              restart;
  logic              div_start;
  rus_pkg::div_rsp_t div_rsp;

  // Handshakes
  assign cfg_ready_o = (state_q == rus_pkg::S_IDLE);
  assign in_ready_o  = (state_q == rus_pkg::S_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Clamp written count into the supported range
  always_comb begin
    if (participant_count_i < CountLow) begin
      cfg_eff = CountLow;
    end else if (participant_count_i > CountHigh) begin
      cfg_eff = CountHigh;
    end else begin
      cfg_eff = participant_count_i;
    end
  end

  assign hit       = pend_q && (rd_data_q == vis_rank_q);
  assign dump_last = (CntW'(idx_q + 1'b1) == vc_q);

  // Remainder unit, started on the input beat with the post-removal count
  rus_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (random_value_i),
    .divisor_i  (RankW'(rc_q - 1'b1)),
    .rsp_o      (div_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rus_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = rus_pkg::S_SCAN;
        end
      end
      rus_pkg::S_SCAN: begin
        if (hit) begin
          state_d = rus_pkg::S_SWAP;
        end else if (idx_q >= rc_q) begin
          state_d = rus_pkg::S_ERR;
        end
      end
      rus_pkg::S_SWAP: begin
        if (rc_q == CntW'(1)) begin
          state_d = rus_pkg::S_DUMP_RD;
        end else begin
          state_d = rus_pkg::S_PICK_WAIT;
        end
      end
      rus_pkg::S_PICK_WAIT: begin
        if (div_rsp.done) begin
          state_d = rus_pkg::S_PICK_OUT;
        end
      end
      rus_pkg::S_PICK_OUT,
      rus_pkg::S_ERR: begin
        if (out_free) begin
          state_d = rus_pkg::S_IDLE;
        end
      end
      rus_pkg::S_DUMP_RD: begin
        state_d = rus_pkg::S_DUMP_OUT;
      end
      rus_pkg::S_DUMP_OUT: begin
        if (out_free) begin
          state_d = dump_last ? rus_pkg::S_IDLE : rus_pkg::S_DUMP_RD;
        end
      end
      default: begin
        state_d = rus_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    rem_wr       = 1'b0;
    vo_wr        = 1'b0;
    vo_rd_en     = 1'b0;
    restart      = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    out_kind_d   = rus_pkg::KIND_PICK;
    out_rank_d   = '0;
    out_status_d = rus_pkg::ST_OK;
    out_last_d   = 1'b1;
    eff_d        = eff_q;
    rc_d         = rc_q;
    vc_d         = vc_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    slot_d       = slot_q;
    vis_rank_d   = vis_rank_q;
    unique case (state_q)
      rus_pkg::S_IDLE: begin
        if (cfg_acc) begin
          eff_d   = cfg_eff;
          rc_d    = cfg_eff;
          vc_d    = '0;
          restart = 1'b1;
        end else if (in_acc) begin
          vis_rank_d = visited_rank_i;
          idx_d      = '0;
          pend_d     = 1'b0;
          div_start  = 1'b1;
        end
      end
      rus_pkg::S_SCAN: begin
        // compare last read, on a hit fetch the last live entry
        if (hit) begin
          slot_d  = RankW'(idx_q - 1'b1);
          rd_en   = 1'b1;
          rd_addr = RankW'(rc_q - 1'b1);
        end else if (idx_q < rc_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[RankW-1:0];
          idx_d   = idx_q + 1'b1;
          pend_d  = 1'b1;
        end
      end
      rus_pkg::S_SWAP: begin
        // move last entry into the hole, log the visit
        rem_wr = 1'b1;
        vo_wr  = 1'b1;
        vc_d   = vc_q + 1'b1;
        rc_d   = rc_q - 1'b1;
        idx_d  = '0;
      end
      rus_pkg::S_PICK_WAIT: begin
        if (div_rsp.done) begin
          rd_en   = 1'b1;
          rd_addr = div_rsp.rem;
        end
      end
      rus_pkg::S_PICK_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_rank_d = rd_data_q;
        end
      end
      rus_pkg::S_ERR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = rus_pkg::ST_ERR;
        end
      end
      rus_pkg::S_DUMP_RD: begin
        vo_rd_en = 1'b1;
      end
      rus_pkg::S_DUMP_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = rus_pkg::KIND_ORDER;
          out_rank_d   = vo_rd_q;
          out_status_d = rus_pkg::ST_DONE;
          out_last_d   = dump_last;
          if (dump_last) begin
            restart = 1'b1;
            vc_d    = '0;
            rc_d    = eff_q;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        restart = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rus_pkg::S_IDLE;
      eff_q       <= CountHigh;
      rc_q        <= CountHigh;
      vc_q        <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rem_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      eff_q   <= eff_d;
      rc_q    <= rc_d;
      vc_q    <= vc_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (restart) begin
        rem_vld_q <= '0;
      end else if (rem_wr) begin
        rem_vld_q[slot_q] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    vis_rank_q <= vis_rank_d;
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_rank_q   <= out_rank_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  // Remaining list memory; an entry never written reads as its own index
  always_ff @(posedge clk_i) begin
    if (rem_wr) begin
      rem_mem[slot_q] <= rd_data_q;
    end
    if (rd_en) begin
      rd_data_q <= rem_vld_q[rd_addr] ? rem_mem[rd_addr] : rd_addr;
    end
  end

  // Visit order memory
  always_ff @(posedge clk_i) begin
    if (vo_wr) begin
      vo_mem[vc_q[RankW-1:0]] <= vis_rank_q;
    end
    if (vo_rd_en) begin
      vo_rd_q <= vo_mem[idx_q[RankW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign rank_out_o  = out_rank_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // Checks
  `RUS_ASSERT_NOW(a_count_sum, 1'b1,
    (CntW + 1)'(rc_q) + (CntW + 1)'(vc_q) == (CntW + 1)'(eff_q),
    "remaining plus visited count differs from round size")
  `RUS_ASSERT_NOW(a_kind_status, out_valid_o,
    (kind_o == rus_pkg::KIND_ORDER) == (status_o == rus_pkg::ST_DONE),
    "order beat without finished status")
  `RUS_ASSERT_NOW(a_err_beat, out_valid_o && (status_o == rus_pkg::ST_ERR),
    last_o && (rank_out_o == '0) && (kind_o == rus_pkg::KIND_PICK),
    "malformed error beat")
  `RUS_ASSERT_NEXT(a_accept_scan, in_valid_i && in_ready_o,
    state_q == rus_pkg::S_SCAN && vc_q == $past(vc_q),
    "accepted beat did not start a scan")

endmodule
